// ===== rtl/emn_pkg.sv =====
// Shared types and constants of the Euler normal matrix block.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package emn_pkg;

   typedef struct packed {
      logic [15:0]        angle_x;
      logic [15:0]        angle_y;
      logic [15:0]        angle_z;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic               zero_scale;
   } rsp_type;

   // queue entry: the request plus its zero-scale class (bit 0 = x)
   typedef struct packed {
      req_type    req;
      logic [2:0] zero;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = 2;

   // sine pipeline: fold, square, six Horner steps of three stages, final product
   localparam int unsigned TAYLOR_STEPS = 6;
   localparam int unsigned SIN_LAT      = 21;

   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;

   // factorial ratios 156 110 72 42 20 6 split as power of two times odd part
   localparam int TAYLOR_SHIFT [TAYLOR_STEPS] = '{2, 1, 3, 1, 2, 1};
   localparam int TAYLOR_ODD   [TAYLOR_STEPS] = '{39, 55, 9, 21, 5, 3};

   localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] OUT_MIN = {1'b1, 31'd0};

endpackage

`default_nettype wire

// ===== rtl/emn_front.sv =====
// Front stage: takes requests, flags zero scales, hands entries to the queue.
// Depends on emn_pkg.
`default_nettype none

module emn_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire emn_pkg::req_type     req_data,
   input  wire emn_pkg::q_stat_type  q_stat,
   output logic                      q_push,
   output emn_pkg::entry_type        q_data
);

   logic               front_v_ff, front_v_in;
   emn_pkg::entry_type front_ff, front_in;
   logic               accept;

   assign req_full = front_v_ff && q_stat.full;
   assign accept   = req_push && !req_full;
   assign q_push   = front_v_ff && !q_stat.full;
   assign q_data   = front_ff;

   always_comb begin
      front_v_in = accept || (front_v_ff && q_stat.full);
      front_in   = front_ff;
      if (accept) begin
         front_in.req  = req_data;
         front_in.zero = {req_data.scale_z == 16'sd0,
                          req_data.scale_y == 16'sd0,
                          req_data.scale_x == 16'sd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else begin
         front_v_ff <= front_v_in;
      end
      front_ff <= front_in;
   end

endmodule

`default_nettype wire

// ===== rtl/emn_queue.sv =====
// Short entry queue between front and back stages.
// Depends on emn_pkg.
`default_nettype none

module emn_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire emn_pkg::entry_type  wr_data,
   input  wire logic                pop,
   output emn_pkg::entry_type       rd_data,
   output emn_pkg::q_stat_type      stat
);

   localparam int unsigned PW = emn_pkg::QPTR_BITS;

   emn_pkg::entry_type mem_ff [emn_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]        cnt_ff, cnt_in;

   assign stat.full  = cnt_ff == (PW+1)'(emn_pkg::QUEUE_DEPTH);
   assign stat.empty = cnt_ff == '0;
   assign rd_data    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/emn_sine.sv =====
// Pipelined sine of a turn fraction, Q2.30 result, Taylor/Horner in stages.
// Depends on emn_pkg.
`default_nettype none

module emn_sine #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [ANGLE_BITS-1:0] angle,
   output logic signed [31:0]         value
);

   localparam int AB = ANGLE_BITS;
   localparam int FW = AB - 1;
   localparam int NS = emn_pkg::TAYLOR_STEPS;
   localparam logic [FW-1:0] QUARTER = FW'(1) << (AB - 2);

   // fold to first quadrant, scale to radians
   logic [1:0]     quad;
   logic [FW-1:0]  f_raw, f;
   logic [FW+30:0] t_prod;
   logic [30:0]    t0_ff;
   logic           n0_ff;

   assign quad   = angle[AB-1:AB-2];
   assign f_raw  = {1'b0, angle[AB-3:0]};
   assign f      = quad[0] ? QUARTER - f_raw : f_raw;
   assign t_prod = (FW+31)'(f) * (FW+31)'(emn_pkg::Q30_HALF_PI);

   // t squared
   logic [61:0] tsq;
   logic [30:0] t1_ff;
   logic [31:0] t2_1_ff;
   logic        n1_ff;

   assign tsq = 62'(t0_ff) * 62'(t0_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff   <= 31'(t_prod >> (AB - 2));
         n0_ff   <= quad[1];
         t1_ff   <= t0_ff;
         t2_1_ff <= 32'(tsq >> 30);
         n1_ff   <= n0_ff;
      end
   end

   // Horner steps: multiply, reciprocal multiply, correct and subtract
   logic [30:0] r_src  [NS];
   logic [30:0] t_src  [NS];
   logic [31:0] t2_src [NS];
   logic        n_src  [NS];

   logic [30:0] a_x_ff [NS];
   logic [30:0] a_t_ff [NS];
   logic [31:0] a_t2_ff[NS];
   logic        a_n_ff [NS];
   logic [30:0] b_q_ff [NS];
   logic [30:0] b_x_ff [NS];
   logic [30:0] b_t_ff [NS];
   logic [31:0] b_t2_ff[NS];
   logic        b_n_ff [NS];
   logic [30:0] r_ff   [NS];
   logic [30:0] c_t_ff [NS];
   logic [31:0] c_t2_ff[NS];
   logic        c_n_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_step
      localparam logic [30:0] ODD   = 31'(emn_pkg::TAYLOR_ODD[k]);
      localparam logic [30:0] RECIP = 31'((64'd1 << 32) / 64'(emn_pkg::TAYLOR_ODD[k]));
      localparam int          SH    = emn_pkg::TAYLOR_SHIFT[k];

      logic [62:0] a_prod;
      logic [61:0] b_prod;
      logic [30:0] c_rem, c_q;

      if (k == 0) begin : g_first
         assign r_src[k]  = emn_pkg::Q30_ONE;
         assign t_src[k]  = t1_ff;
         assign t2_src[k] = t2_1_ff;
         assign n_src[k]  = n1_ff;
      end else begin : g_next
         assign r_src[k]  = r_ff[k-1];
         assign t_src[k]  = c_t_ff[k-1];
         assign t2_src[k] = c_t2_ff[k-1];
         assign n_src[k]  = c_n_ff[k-1];
      end

      assign a_prod = 63'(t2_src[k]) * 63'(r_src[k]);
      assign b_prod = 62'(a_x_ff[k]) * 62'(RECIP);
      assign c_rem  = b_x_ff[k] - 31'(62'(b_q_ff[k]) * 62'(ODD));
      assign c_q    = b_q_ff[k] + 31'(c_rem >= ODD);

      always_ff @(posedge clock) begin
         if (en) begin
            a_x_ff[k]  <= 31'(a_prod >> (30 + SH));
            a_t_ff[k]  <= t_src[k];
            a_t2_ff[k] <= t2_src[k];
            a_n_ff[k]  <= n_src[k];
            b_q_ff[k]  <= 31'(b_prod >> 32);
            b_x_ff[k]  <= a_x_ff[k];
            b_t_ff[k]  <= a_t_ff[k];
            b_t2_ff[k] <= a_t2_ff[k];
            b_n_ff[k]  <= a_n_ff[k];
            r_ff[k]    <= emn_pkg::Q30_ONE - c_q;
            c_t_ff[k]  <= b_t_ff[k];
            c_t2_ff[k] <= b_t2_ff[k];
            c_n_ff[k]  <= b_n_ff[k];
         end
      end
   end

   // final t * r and sign of the lower half turn
   logic [61:0] fin_prod;
   logic [30:0] fin_s;

   assign fin_prod = 62'(c_t_ff[NS-1]) * 62'(r_ff[NS-1]);
   assign fin_s    = 31'(fin_prod >> 30);

   always_ff @(posedge clock) begin
      if (en) begin
         value <= c_n_ff[NS-1] ? -$signed({1'b0, fin_s}) : $signed({1'b0, fin_s});
      end
   end

endmodule

`default_nettype wire

// ===== rtl/emn_back.sv =====
// Back pipeline: sines, matrix products, division by scale, saturation.
// Depends on emn_pkg and emn_sine.
`default_nettype none

module emn_back #(
   parameter int ANGLE_BITS    = 16,
   parameter int OUT_FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire emn_pkg::q_stat_type q_stat,
   input  wire emn_pkg::entry_type  q_data,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output emn_pkg::rsp_type         rsp_data
);

   localparam int AB  = ANGLE_BITS;
   localparam int XW  = OUT_FRAC_BITS + 11;
   localparam int NW  = OUT_FRAC_BITS + 41;
   localparam int NST = emn_pkg::SIN_LAT + 4 + XW;
   localparam logic [AB-1:0] QA = AB'(1) << (AB - 2);

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] sz;
      logic [2:0]         zero;
   } side_type;

   typedef struct packed {
      logic zero;
      logic neg;
      logic e_neg;
      logic e_zero;
   } lane_flag_type;

   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic [31:0] ma, mb, m;
      logic [63:0] p;
      ma = a[31] ? 32'(-a) : 32'(a);
      mb = b[31] ? 32'(-b) : 32'(b);
      p  = {32'd0, ma} * {32'd0, mb};
      m  = 32'((p + 64'd536870912) >> 30);
      return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
   endfunction

   logic           en, out_v_ff, out_v_in;
   logic [NST-1:0] v_ff;
   emn_pkg::rsp_type out_in;

   assign en        = !out_v_ff || rsp_pop;
   assign q_pop     = en && !q_stat.empty;
   assign rsp_empty = !out_v_ff;

   // angles: index 2p is cosine, 2p+1 sine; pairs y, x, z
   logic [AB+15:0]     ext  [3];
   logic [AB-1:0]      am   [3];
   logic [AB-1:0]      sang [6];
   logic signed [31:0] sv   [6];

   assign ext[0] = {{AB{1'b0}}, q_data.req.angle_y};
   assign ext[1] = {{AB{1'b0}}, q_data.req.angle_x};
   assign ext[2] = {{AB{1'b0}}, q_data.req.angle_z};

   for (genvar p = 0; p < 3; p++) begin : g_ang
      assign am[p]       = ext[p][AB-1:0];
      assign sang[2*p]   = am[p] + QA;
      assign sang[2*p+1] = am[p];
   end

   for (genvar i = 0; i < 6; i++) begin : g_sin
      emn_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sine (
         .clock (clock),
         .en    (en),
         .angle (sang[i]),
         .value (sv[i])
      );
   end

   logic signed [31:0] c1, s1, c2, s2, c3, s3;
   assign c1 = sv[0];
   assign s1 = sv[1];
   assign c2 = sv[2];
   assign s2 = sv[3];
   assign c3 = sv[4];
   assign s3 = sv[5];

   side_type sd_ff [emn_pkg::SIN_LAT];
   side_type p1_sd_ff, p2_sd_ff, p3_sd_ff;
   logic signed [31:0] p1_ff [10];
   logic signed [31:0] p2_ff [10];
   logic signed [31:0] t_ff  [4];
   logic signed [31:0] p1_s2_ff, p1_s3_ff, p2_s2_ff;
   logic signed [32:0] e_ff  [9];

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= {q_data.req.scale_x, q_data.req.scale_y, q_data.req.scale_z, q_data.zero};
         for (int i = 1; i < int'(emn_pkg::SIN_LAT); i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
         // pair products
         p1_ff[0] <= mulq(c2, c3);
         p1_ff[1] <= mulq(c1, s3);
         p1_ff[2] <= mulq(c3, s1);
         p1_ff[3] <= mulq(s1, s3);
         p1_ff[4] <= mulq(c1, c3);
         p1_ff[5] <= mulq(s1, s2);
         p1_ff[6] <= mulq(c1, s2);
         p1_ff[7] <= mulq(c2, s3);
         p1_ff[8] <= mulq(c2, s1);
         p1_ff[9] <= mulq(c1, c2);
         p1_s2_ff <= s2;
         p1_s3_ff <= s3;
         p1_sd_ff <= sd_ff[emn_pkg::SIN_LAT-1];
         // triple products, left to right
         p2_ff    <= p1_ff;
         t_ff[0]  <= mulq(p1_ff[2], p1_s2_ff);
         t_ff[1]  <= mulq(p1_ff[4], p1_s2_ff);
         t_ff[2]  <= mulq(p1_ff[5], p1_s3_ff);
         t_ff[3]  <= mulq(p1_ff[6], p1_s3_ff);
         p2_s2_ff <= p1_s2_ff;
         p2_sd_ff <= p1_sd_ff;
         // entries
         e_ff[0]  <= 33'(p2_ff[0]);
         e_ff[1]  <= 33'(p2_ff[1]) + 33'(t_ff[0]);
         e_ff[2]  <= 33'(p2_ff[3]) - 33'(t_ff[1]);
         e_ff[3]  <= -33'(p2_ff[7]);
         e_ff[4]  <= 33'(p2_ff[4]) - 33'(t_ff[2]);
         e_ff[5]  <= 33'(p2_ff[2]) + 33'(t_ff[3]);
         e_ff[6]  <= 33'(p2_s2_ff);
         e_ff[7]  <= -33'(p2_ff[8]);
         e_ff[8]  <= 33'(p2_ff[9]);
         p3_sd_ff <= p2_sd_ff;
      end
   end

   // per-entry division by the row scale, one quotient bit per stage
   logic [XW-1:0]      x4_ff  [9];
   logic [15:0]        d4_ff  [9];
   lane_flag_type      f4_ff  [9];
   logic [15:0]        rem_ff [9][XW];
   logic [XW-1:0]      x_ff   [9][XW];
   logic [XW-1:0]      q_ff   [9][XW];
   logic [15:0]        d_ff   [9][XW];
   lane_flag_type      fl_ff  [9][XW];
   logic signed [31:0] sat    [9];

   for (genvar j = 0; j < 9; j++) begin : g_lane
      logic signed [15:0] sc;
      logic               zr;
      logic [31:0]        me;
      logic [15:0]        ms;
      logic [NW-1:0]      num;

      assign sc  = (j < 3) ? p3_sd_ff.sx : ((j < 6) ? p3_sd_ff.sy : p3_sd_ff.sz);
      assign zr  = p3_sd_ff.zero[j/3];
      assign me  = e_ff[j][32] ? 32'(-e_ff[j]) : 32'(e_ff[j]);
      assign ms  = sc[15] ? 16'(-sc) : 16'(sc);
      assign num = (NW'(me) << (OUT_FRAC_BITS + 8)) + (NW'(ms) << 29);

      always_ff @(posedge clock) begin
         if (en) begin
            x4_ff[j]        <= XW'(num >> 30);
            d4_ff[j]        <= ms;
            f4_ff[j].zero   <= zr;
            f4_ff[j].neg    <= e_ff[j][32] ^ sc[15];
            f4_ff[j].e_neg  <= e_ff[j][32];
            f4_ff[j].e_zero <= e_ff[j] == '0;
         end
      end

      for (genvar s = 0; s < XW; s++) begin : g_div
         logic [15:0]   r_src;
         logic [XW-1:0] x_src, q_src;
         logic [15:0]   d_src;
         lane_flag_type f_src;
         logic [16:0]   sh;
         logic          ge;

         if (s == 0) begin : g_first
            assign r_src = '0;
            assign x_src = x4_ff[j];
            assign q_src = '0;
            assign d_src = d4_ff[j];
            assign f_src = f4_ff[j];
         end else begin : g_next
            assign r_src = rem_ff[j][s-1];
            assign x_src = x_ff[j][s-1];
            assign q_src = q_ff[j][s-1];
            assign d_src = d_ff[j][s-1];
            assign f_src = fl_ff[j][s-1];
         end

         assign sh = {r_src, x_src[XW-1]};
         assign ge = sh >= {1'b0, d_src};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j][s] <= ge ? 16'(sh - {1'b0, d_src}) : 16'(sh);
               x_ff[j][s]   <= x_src << 1;
               q_ff[j][s]   <= {q_src[XW-2:0], ge};
               d_ff[j][s]   <= d_src;
               fl_ff[j][s]  <= f_src;
            end
         end
      end

      logic [63:0]   qx;
      lane_flag_type fz;
      assign qx = 64'(q_ff[j][XW-1]);
      assign fz = fl_ff[j][XW-1];

      always_comb begin
         priority if (fz.zero) begin
            sat[j] = fz.e_zero ? 32'sd0 : (fz.e_neg ? emn_pkg::OUT_MIN : emn_pkg::OUT_MAX);
         end else if (fz.neg) begin
            sat[j] = (qx > (64'd1 << 31)) ? emn_pkg::OUT_MIN : $signed(32'(64'd0 - qx));
         end else begin
            sat[j] = (qx > 64'h7FFF_FFFF) ? emn_pkg::OUT_MAX : $signed(32'(qx));
         end
      end
   end

   always_comb begin
      out_in.m00        = sat[0];
      out_in.m01        = sat[1];
      out_in.m02        = sat[2];
      out_in.m10        = sat[3];
      out_in.m11        = sat[4];
      out_in.m12        = sat[5];
      out_in.m20        = sat[6];
      out_in.m21        = sat[7];
      out_in.m22        = sat[8];
      out_in.zero_scale = fl_ff[0][XW-1].zero || fl_ff[3][XW-1].zero
                          || fl_ff[6][XW-1].zero;
      out_v_in          = en ? v_ff[NST-1] : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (en) begin
            v_ff <= {v_ff[NST-2:0], q_pop};
         end
         out_v_ff <= out_v_in;
      end
      if (en) begin
         rsp_data <= out_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/euler_normal_matrix_top.sv =====
// Path from request transfer to result:
//   front register, queue, 21-stage sine pipeline, 4 product stages,
//   OUT_FRAC_BITS + 11 divider stages (one quotient bit each), output register.
// Throughput: one request per cycle; the back pipeline holds while a result waits.
// Reset: synchronous, active high; empties front, queue and pipeline. No state.
// Top level of the Euler normal matrix block; depends on emn_pkg, emn_front,
// emn_queue, emn_sine and emn_back.
`default_nettype none

module euler_normal_matrix_top #(
   parameter int ANGLE_BITS    = 16,
   parameter int OUT_FRAC_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel: transfer on push && !full
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire emn_pkg::req_type req_data,
   // result channel: transfer on pop && !empty
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output emn_pkg::rsp_type      rsp_data
);

   // front -> queue
   logic                q_push;
   emn_pkg::entry_type  q_wr;
   // queue -> back
   logic                q_pop;
   emn_pkg::entry_type  q_rd;
   emn_pkg::q_stat_type q_stat;

   // front: one register, zero-scale classification
   emn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_data   (q_wr)
   );

   // decoupling queue, lets front and back stall independently
   emn_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr),
      .pop     (q_pop),
      .rd_data (q_rd),
      .stat    (q_stat)
   );

   // back: all arithmetic, single stall line driven by the output register
   emn_back #(
      .ANGLE_BITS    (ANGLE_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (q_rd),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // queue never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue written while full");

   // queue never read when empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue read while empty");

   // front only backs up when the queue is full
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      req_full |-> q_stat.full)
      else $error("request side stalled with queue space free");

endmodule

`default_nettype wire
